/* rtl/dnrh_pkg.sv */
package dnrh_pkg;

  localparam int unsigned DNRH_MAX_LABEL = 32;
  localparam int unsigned DNRH_CFG_IDX_W = 2;
  localparam int unsigned DNRH_CFG_DATA_W = 16;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] CLASS_HI = 8'h80;
  localparam logic [7:0] CLASS_LO = 8'h01;

  typedef enum logic [DNRH_CFG_IDX_W-1:0] {
    CFG_RECORD_TYPE = 2'd0,
    CFG_TTL_VALUE   = 2'd1,
    CFG_DATA_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    HDR_TERM     = 4'd0,
    HDR_TYPE_HI  = 4'd1,
    HDR_TYPE_LO  = 4'd2,
    HDR_CLASS_HI = 4'd3,
    HDR_CLASS_LO = 4'd4,
    HDR_TTL_3    = 4'd5,
    HDR_TTL_2    = 4'd6,
    HDR_TTL_1    = 4'd7,
    HDR_TTL_0    = 4'd8,
    HDR_DLEN_HI  = 4'd9,
    HDR_DLEN_LO  = 4'd10
  } hdr_pos_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_HDR
  } state_e;

  typedef enum logic [1:0] {
    SEL_LEN,
    SEL_DATA,
    SEL_HDR
  } out_sel_e;

  typedef struct packed {
    logic     accept;
    logic     out_load;
    out_sel_e out_sel;
    logic     last_of_run;
    logic     record_done;
    logic     label_clr;
  } dnrh_cmd_t;

  typedef struct packed {
    logic is_dot;
    logic in_end;
    logic count_zero;
    logic end_q;
    logic data_last;
    logic hdr_last;
    logic out_free;
  } dnrh_status_t;

endpackage

/* rtl/dns_name_record_header_encoder_unit.sv */
// A plain name character is taken and gives no output.
// A dot closing an n-byte label: n+1 output bytes, one per cycle after accept while the output is not stalled.
// End of name adds the label flush plus 11 header bytes, one per cycle while the output is not stalled.
// Output stalls hold the sequencer; input is held until the last byte of the run is loaded.
// Reset (async, active low) clears label count, flags and state, and loads
// the register defaults; the label buffer RAM is not cleared.
module dns_name_record_header_encoder_unit
  import dnrh_pkg::*;
#(
  parameter int unsigned MaxLabel = DNRH_MAX_LABEL
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [DNRH_CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DNRH_CFG_DATA_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 name_char_i,
  input  logic                       name_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  output logic                       record_done_o,
  output logic                       label_overflow_o
);

  dnrh_cmd_t    cmd;
  dnrh_status_t status;

  assign cfg_ready_o = 1'b1;

  dnrh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dnrh_datapath #(
    .MaxLabel (MaxLabel)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .name_char_i      (name_char_i),
    .name_end_i       (name_end_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o),
    .record_done_o    (record_done_o),
    .label_overflow_o (label_overflow_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

/* rtl/dnrh_ctrl.sv */
module dnrh_ctrl
  import dnrh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dnrh_status_t status_i,
  output dnrh_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.out_sel      = SEL_LEN;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (status_i.is_dot) begin
            if (!status_i.count_zero) begin
              state_d = ST_LEN;
            end else if (status_i.in_end) begin
              state_d = ST_HDR;
            end
          end else if (status_i.in_end) begin
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_LEN;
          state_d        = ST_DATA;
        end
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_DATA;
          if (status_i.data_last) begin
            cmd_o.label_clr   = 1'b1;
            cmd_o.last_of_run = !status_i.end_q;
            state_d           = status_i.end_q ? ST_HDR : ST_IDLE;
          end
        end
      end
      ST_HDR: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_HDR;
          if (status_i.hdr_last) begin
            cmd_o.last_of_run = 1'b1;
            cmd_o.record_done = 1'b1;
            state_d           = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dnrh_datapath.sv */
module dnrh_datapath
  import dnrh_pkg::*;
#(
  parameter int unsigned MaxLabel = DNRH_MAX_LABEL
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 name_char_i,
  input  logic                       name_end_i,
  input  logic                       cfg_valid_i,
  input  logic [DNRH_CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DNRH_CFG_DATA_W-1:0] cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  output logic                       record_done_o,
  output logic                       label_overflow_o,
  input  dnrh_cmd_t                  cmd_i,
  output dnrh_status_t               status_o
);

  localparam int unsigned CntW  = $clog2(MaxLabel + 1);
  localparam int unsigned AddrW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;

  logic [7:0]      label_mem [MaxLabel];
  logic [7:0]      rdata_q;
  logic [CntW-1:0] count_q, idx_q;
  logic [CntW-1:0] idx_inc;
  logic            ovf_q, end_q;
  logic [3:0]      hdr_idx_q;
  logic [7:0]      record_type_q;
  logic [15:0]     ttl_value_q, data_length_q;

  logic            out_valid_q;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            last_q, done_q, out_ovf_q, out_ovf_d;

  logic            is_dot, has_room, mem_we, mem_re;
  logic [AddrW-1:0] rd_addr;

  assign is_dot   = (name_char_i == DOT_CHAR);
  assign has_room = (count_q < CntW'(MaxLabel));
  assign idx_inc  = idx_q + CntW'(1);
  assign mem_we   = cmd_i.accept && !is_dot && has_room;
  assign mem_re   = cmd_i.out_load &&
                    ((cmd_i.out_sel == SEL_LEN) ||
                     ((cmd_i.out_sel == SEL_DATA) && !status_o.data_last));
  assign rd_addr  = (cmd_i.out_sel == SEL_LEN) ? '0 : idx_inc[AddrW-1:0];

  always_comb begin
    status_o.is_dot     = is_dot;
    status_o.in_end     = name_end_i;
    status_o.count_zero = (count_q == '0);
    status_o.end_q      = end_q;
    status_o.data_last  = (idx_inc == count_q);
    status_o.hdr_last   = (hdr_idx_q == HDR_DLEN_LO);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      label_mem[count_q[AddrW-1:0]] <= name_char_i;
    end
    if (mem_re) begin
      rdata_q <= label_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      ovf_q         <= 1'b0;
      end_q         <= 1'b0;
      idx_q         <= '0;
      hdr_idx_q     <= '0;
      record_type_q <= 8'd1;
      ttl_value_q   <= 16'd120;
      data_length_q <= 16'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_RECORD_TYPE: record_type_q <= cfg_data_i[7:0];
          CFG_TTL_VALUE:   ttl_value_q   <= cfg_data_i;
          CFG_DATA_LENGTH: data_length_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        end_q     <= name_end_i;
        hdr_idx_q <= '0;
        if (!is_dot) begin
          if (has_room) begin
            count_q <= count_q + CntW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
      end
      if (cmd_i.out_load) begin
        unique case (cmd_i.out_sel)
          SEL_LEN:  idx_q     <= '0;
          SEL_DATA: idx_q     <= idx_inc;
          SEL_HDR:  hdr_idx_q <= hdr_idx_q + 4'd1;
          default: ;
        endcase
      end
      if (cmd_i.label_clr) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_byte_d = 8'h00;
    out_ovf_d  = 1'b0;
    unique case (cmd_i.out_sel)
      SEL_LEN: begin
        out_byte_d = 8'(count_q);
        out_ovf_d  = ovf_q;
      end
      SEL_DATA: begin
        out_byte_d = rdata_q;
        out_ovf_d  = ovf_q;
      end
      SEL_HDR: begin
        unique case (hdr_pos_e'(hdr_idx_q))
          HDR_TYPE_LO:  out_byte_d = record_type_q;
          HDR_CLASS_HI: out_byte_d = CLASS_HI;
          HDR_CLASS_LO: out_byte_d = CLASS_LO;
          HDR_TTL_1:    out_byte_d = ttl_value_q[15:8];
          HDR_TTL_0:    out_byte_d = ttl_value_q[7:0];
          HDR_DLEN_HI:  out_byte_d = data_length_q[15:8];
          HDR_DLEN_LO:  out_byte_d = data_length_q[7:0];
          default:      out_byte_d = 8'h00;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= out_byte_d;
      last_q     <= cmd_i.last_of_run;
      done_q     <= cmd_i.record_done;
      out_ovf_q  <= out_ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_of_run_o    = last_q;
  assign record_done_o    = done_q;
  assign label_overflow_o = out_ovf_q;

endmodule
